// ===== rtl/fds_pkg.sv =====
// fds_pkg: shared types and constants of the frame duration sequencer.
// Holds the word layouts, frame entry layout, action codes and register map.
// No dependencies.
`default_nettype none

package fds_pkg;

  localparam int FRAMES   = 32;
  localparam int FRAME_AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int TOTAL_W  = $clog2(FRAMES + 1);
  localparam int INDEX_W  = 5;
  localparam int ACC_W    = 17;
  localparam int TICK_W   = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_ADD_GLYPH   = 3'd1,
    ACT_ADD_TEXTURE = 3'd2,
    ACT_PLAY        = 3'd3,
    ACT_PAUSE       = 3'd4,
    ACT_STOP        = 3'd5,
    ACT_RESET       = 3'd6
  } action_t;

  typedef enum logic [0:0] {
    REG_LOOPING       = 1'b0,
    REG_DEFAULT_COLOR = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [TICK_W-1:0] elapsed_ticks;
    logic [7:0]        glyph;
    logic [15:0]       texture_id;
    logic [7:0]        fg_color;
    logic [7:0]        bg_color;
    logic [TICK_W-1:0] duration_ticks;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [INDEX_W-1:0] current_index;
    logic [7:0]         current_glyph;
    logic [15:0]        current_texture;
    logic [7:0]         current_fg;
    logic [7:0]         current_bg;
    logic               now_playing;
    logic               is_done;
  } result_t;

  typedef struct packed {
    logic [7:0]        glyph;
    logic [15:0]       texture;
    logic [7:0]        fg;
    logic [7:0]        bg;
    logic [TICK_W-1:0] duration;
  } frame_entry_t;

  typedef struct packed {
    logic                looping;
    logic [7:0]          default_color;
  } cfg_t;

  typedef struct packed {
    logic                wr_en;
    logic [FRAME_AW-1:0] wr_addr;
    frame_entry_t        wr_entry;
    logic                rd_en;
    logic [FRAME_AW-1:0] rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/frame_duration_sequencer.sv =====
// frame_duration_sequencer: top level, configuration registers on an APB port,
// frame table memory and sequencer control. Depends on fds_pkg, fds_frame_store
// and fds_ctrl.
`default_nettype none

// Channel   Signals                                    Direction  Payload
// item      item_valid, item_ready, item               in         item_t
// result    result_valid, result_ready, result         out        result_t
// config    psel, penable, pwrite, paddr, pwdata,      in/out     looping @0x0,
//           prdata, pready                                        default_color @0x4
//
// Steps: an item passes accept, table read and check when no frame is passed;
// a tick repeats the table read and check for every frame it passes, set by the
// single read port of the frame table and its registered read data.
// Reset: synchronous, clears pointer, frame count, accumulator and flags; the
// frame table itself is not cleared, entries above the frame count are never read.
// Stalls: the result sits in an output register; the next word is accepted while
// it waits, and the check step holds its read data until the register frees up.

module frame_duration_sequencer
  import fds_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire item_t              item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output result_t                 result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  cfg_t         cfg;
  mem_req_t     mem_req;
  frame_entry_t rd_entry;
  logic         cfg_wr;
  reg_index_t   reg_sel;

  // Zero wait states; decode on the word address only.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_LOOPING:       cfg.looping       <= pwdata[0];
        REG_DEFAULT_COLOR: cfg.default_color <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_LOOPING:       prdata = PDATA_W'(cfg.looping);
      REG_DEFAULT_COLOR: prdata = PDATA_W'(cfg.default_color);
      default:           prdata = '0;
    endcase
  end

  // Frame table: one write for an add, one read per step of the frame loop.
  fds_frame_store u_store (
    .clk      (clk),
    .req      (mem_req),
    .rd_entry (rd_entry)
  );

  // Action decode, frame stepping and the result register.
  fds_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mem_req      (mem_req),
    .rd_entry     (rd_entry)
  );

endmodule

`default_nettype wire

// ===== rtl/fds_frame_store.sv =====
// fds_frame_store: frame table memory, one write and one read port.
// Read data is registered and holds until the next read. Depends on fds_pkg.
`default_nettype none

module fds_frame_store
  import fds_pkg::*;
(
  input  wire logic         clk,
  input  wire mem_req_t     req,
  output frame_entry_t      rd_entry
);

  frame_entry_t mem [FRAMES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_entry <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fds_ctrl.sv =====
// fds_ctrl: sequencer control: action decode, frame stepping loop over the
// frame table and the result register. Depends on fds_pkg.
`default_nettype none

module fds_ctrl
  import fds_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  input  wire logic         item_valid,
  output logic              item_ready,
  input  wire item_t        item,
  output logic              result_valid,
  input  wire logic         result_ready,
  output result_t           result,
  output mem_req_t          mem_req,
  input  wire frame_entry_t rd_entry
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  state_t              state;
  logic [TOTAL_W-1:0]  total;
  logic [FRAME_AW-1:0] ptr;
  logic [ACC_W-1:0]    acc;
  logic                play;
  logic                done;
  logic                run;
  logic                accepted;

  logic                take;
  logic                is_add;
  logic                add_ok;
  logic                tick_go;
  logic                hit;
  logic                last;
  logic                out_free;
  logic                emit;
  logic [TOTAL_W-1:0]  ptr_inc;
  logic [ACC_W-1:0]    dur_ext;
  result_t             result_next;

  assign item_ready = (state == S_IDLE);
  assign take       = item_valid && item_ready;
  assign is_add     = (item.action == ACT_ADD_GLYPH) || (item.action == ACT_ADD_TEXTURE);
  assign add_ok     = is_add && (total < TOTAL_W'(FRAMES)) && (item.duration_ticks != '0);
  assign tick_go    = play && (total != '0) && !done;

  assign dur_ext  = ACC_W'(rd_entry.duration);
  assign ptr_inc  = TOTAL_W'(ptr) + TOTAL_W'(1);
  assign last     = (ptr_inc >= total);
  assign hit      = run && (acc >= dur_ext);
  assign out_free = !result_valid || result_ready;
  assign emit     = (state == S_CHECK) && !hit && out_free;

  always_comb begin
    mem_req                  = '0;
    mem_req.wr_en            = take && add_ok;
    mem_req.wr_addr          = FRAME_AW'(total);
    mem_req.wr_entry.glyph   = (item.action == ACT_ADD_GLYPH) ? item.glyph : 8'd0;
    mem_req.wr_entry.texture = (item.action == ACT_ADD_TEXTURE) ? item.texture_id : 16'd0;
    mem_req.wr_entry.fg      = item.fg_color;
    mem_req.wr_entry.bg      = item.bg_color;
    mem_req.wr_entry.duration = item.duration_ticks;
    mem_req.rd_en            = (state == S_READ);
    mem_req.rd_addr          = ptr;
  end

  always_comb begin
    result_next               = '0;
    result_next.accepted      = accepted;
    result_next.current_index = INDEX_W'(ptr);
    result_next.now_playing   = play;
    result_next.is_done       = done;
    if (total == '0) begin
      result_next.current_fg = cfg.default_color;
      result_next.current_bg = cfg.default_color;
    end else begin
      result_next.current_glyph   = rd_entry.glyph;
      result_next.current_texture = rd_entry.texture;
      result_next.current_fg      = rd_entry.fg;
      result_next.current_bg      = rd_entry.bg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total        <= '0;
      ptr          <= '0;
      acc          <= '0;
      play         <= 1'b1;
      done         <= 1'b0;
      run          <= 1'b0;
      accepted     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            accepted <= add_ok;
            run      <= (item.action == ACT_TICK) && tick_go;
            state    <= S_READ;
            unique case (action_t'(item.action))
              ACT_TICK: begin
                if (tick_go) begin
                  acc <= acc + ACC_W'(item.elapsed_ticks);
                end
              end
              ACT_ADD_GLYPH, ACT_ADD_TEXTURE: begin
                if (add_ok) begin
                  total <= total + TOTAL_W'(1);
                end
              end
              ACT_PLAY:  play <= 1'b1;
              ACT_PAUSE: play <= 1'b0;
              ACT_STOP, ACT_RESET: begin
                ptr  <= '0;
                acc  <= '0;
                done <= 1'b0;
                play <= (item.action == ACT_RESET);
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (hit) begin
            // pass this frame, then reread the table at the pointer (advanced, wrapped or held)
            acc   <= acc - dur_ext;
            state <= S_READ;
            if (!last) begin
              ptr <= FRAME_AW'(ptr_inc);
            end else if (cfg.looping) begin
              ptr <= '0;
            end else begin
              done <= 1'b1;
              play <= 1'b0;
              run  <= 1'b0;
            end
          end else if (out_free) begin
            result <= result_next;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
